// ----- hdl/assert_macros.svh -----
// Assertion macros used by the RTL of the keyed resource pool.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Expression holds at every rising clock edge outside reset.
`define KRP_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("keyed resource pool check failed");
// Antecedent in one cycle implies consequent in the next.
`define KRP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("keyed resource pool check failed");
`else
`define KRP_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define KRP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- hdl/krp_pkg.sv -----
// Package of the keyed resource pool: field widths, key layout and sequencer states.
// No dependencies; used by the interfaces, the key store and the top level.
`timescale 1ns / 1ps
package krp_pkg;

   localparam int POOL_SLOTS_DEF = 16;

   localparam int KIND_W   = 1;
   localparam int FMT_W    = 8;
   localparam int DIM_W    = 15;
   localparam int USAGE_W  = 8;
   localparam int TYPE_W   = 3;
   localparam int MIP_W    = 4;
   localparam int LAYER_W  = 12;

   // Stored key: both dimensions, then the descriptor fields.
   localparam int KEY_W = 2 * DIM_W + FMT_W + USAGE_W + TYPE_W + MIP_W + LAYER_W;

   localparam int SLOT_OUT_W  = 4;
   localparam int COUNT_OUT_W = 5;

   localparam logic KIND_ACQUIRE = 1'b0;
   localparam logic KIND_RETIRE  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } krp_state_type;

endpackage

// ----- hdl/krp_req_if.sv -----
// Request channel of the keyed resource pool: valid/ready handshake and key fields.
// Depends on krp_pkg.
`timescale 1ns / 1ps
interface krp_req_if
   import krp_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [FMT_W-1:0]   pixel_format;
   logic [DIM_W-1:0]   tex_width;
   logic [DIM_W-1:0]   tex_height;
   logic [USAGE_W-1:0] usage_bits;
   logic [TYPE_W-1:0]  tex_type;
   logic [MIP_W-1:0]   mip_levels;
   logic [LAYER_W-1:0] array_layers;

   modport source (output valid, kind, pixel_format, tex_width, tex_height, usage_bits,
                   tex_type, mip_levels, array_layers, input ready);
   modport sink (input valid, kind, pixel_format, tex_width, tex_height, usage_bits,
                 tex_type, mip_levels, array_layers, output ready);
endinterface

// ----- hdl/krp_rsp_if.sv -----
// Response channel of the keyed resource pool: valid/ready handshake and result fields.
// Depends on krp_pkg.
`timescale 1ns / 1ps
interface krp_rsp_if
   import krp_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic [SLOT_OUT_W-1:0]  slot_index;
   logic                   created;
   logic                   pool_full;
   logic [COUNT_OUT_W-1:0] live_count;
   logic [COUNT_OUT_W-1:0] retired_count;

   modport source (output valid, slot_index, created, pool_full, live_count, retired_count,
                   input ready);
   modport sink (input valid, slot_index, created, pool_full, live_count, retired_count,
                 output ready);
endinterface

// ----- hdl/krp_key_ram.sv -----
// Key store of the keyed resource pool: one write port, one registered read port.
// Depends on krp_pkg for the key width.
`timescale 1ns / 1ps
module krp_key_ram
   import krp_pkg::*;
#(
   parameter int POOL_SLOTS = POOL_SLOTS_DEF,
   localparam int IDX_W = $clog2(POOL_SLOTS)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [KEY_W-1:0] wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [KEY_W-1:0] rd_data
);

   logic [KEY_W-1:0] key_mem [POOL_SLOTS];
   logic [KEY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= key_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/keyed_resource_pool_top.sv -----
// Top level of the keyed resource pool: scan sequencer, in-use marks, counters, response register.
// Depends on krp_pkg, krp_req_if, krp_rsp_if, krp_key_ram and assert_macros.svh.
//
//   channel | direction | carries
//   req     | in        | kind and the seven key fields of one request
//   rsp     | out       | slot_index, created, pool_full, live_count, retired_count
//
// A retire request finishes in the cycle it is accepted; its response is valid in the following cycle.
// An acquire request scans the allocated slots through the single read port of the key store,
// one slot per cycle, so the time until its response depends on where the matching slot sits
// and on how many slots are allocated; the scan stops at the first free slot with a matching key.
// Reset is synchronous and clears the in-use marks and both counters; the key store is not
// cleared, since only slots below the allocated count are ever read.
// A request is taken only when the sequencer is idle and the response register is empty or being
// emptied; a stalled response therefore holds back the next request but never the current one.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module keyed_resource_pool_top
   import krp_pkg::*;
#(
   parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   krp_req_if.sink    req,
   krp_rsp_if.source  rsp
);

   localparam int IDX_W = $clog2(POOL_SLOTS);
   localparam int CNT_W = $clog2(POOL_SLOTS + 1);

   // Sequencer and scan pipeline state.
   krp_state_type          state_ff, state_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic [CNT_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic                   cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]       cmp_addr_ff, cmp_addr_in;

   // Pool bookkeeping.
   logic [POOL_SLOTS-1:0]  in_use_ff, in_use_in;
   logic [CNT_W-1:0]       alloc_ff, alloc_in;
   logic [CNT_W-1:0]       total_ff, total_in;

   // Response register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SLOT_OUT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic                   rsp_created_ff, rsp_created_in;
   logic                   rsp_full_ff, rsp_full_in;
   logic [COUNT_OUT_W-1:0] rsp_live_ff, rsp_live_in;
   logic [COUNT_OUT_W-1:0] rsp_retired_ff, rsp_retired_in;

   // Key store ports.
   logic                   ram_wr_en;
   logic [IDX_W-1:0]       ram_wr_addr;
   logic                   ram_rd_en;
   logic [KEY_W-1:0]       ram_rd_data;

   logic                   req_fire;
   logic [KEY_W-1:0]       req_key;
   logic                   scan_more;
   logic                   scan_hit;
   logic                   scan_miss;
   logic                   pool_is_full;
   logic [CNT_W-1:0]       retired_now;

   // The request key packs the two dimensions above the descriptor fields.
   assign req_key = {req.tex_height, req.tex_width, req.pixel_format, req.usage_bits,
                     req.tex_type, req.mip_levels, req.array_layers};

   assign req.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign req_fire  = req.valid && req.ready;

   // One key is read per cycle while slots remain; the compare uses the key read the cycle before.
   assign scan_more    = rd_ptr_ff < alloc_ff;
   assign scan_hit     = (state_ff == ST_SCAN) && cmp_vld_ff && !in_use_ff[cmp_addr_ff] &&
                         (ram_rd_data == key_ff);
   assign scan_miss    = (state_ff == ST_SCAN) && !cmp_vld_ff && !scan_more;
   assign pool_is_full = alloc_ff == CNT_W'(POOL_SLOTS);
   assign ram_wr_en    = scan_miss && !pool_is_full;
   assign ram_wr_addr  = alloc_ff[IDX_W-1:0];
   assign ram_rd_en    = (state_ff == ST_SCAN) && !scan_hit && scan_more;

   always_comb begin
      state_in       = state_ff;
      key_in         = key_ff;
      rd_ptr_in      = rd_ptr_ff;
      cmp_vld_in     = 1'b0;
      cmp_addr_in    = cmp_addr_ff;
      in_use_in      = in_use_ff;
      alloc_in       = alloc_ff;
      total_in       = total_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_slot_in    = rsp_slot_ff;
      rsp_created_in = rsp_created_ff;
      rsp_full_in    = rsp_full_ff;
      rsp_live_in    = rsp_live_ff;
      rsp_retired_in = rsp_retired_ff;
      retired_now    = alloc_ff - total_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req.kind == KIND_RETIRE) begin
                  // Free every slot; the allocated slots all become retired.
                  in_use_in      = '0;
                  total_in       = '0;
                  rsp_valid_in   = 1'b1;
                  rsp_slot_in    = '0;
                  rsp_created_in = 1'b0;
                  rsp_full_in    = 1'b0;
                  rsp_live_in    = '0;
                  rsp_retired_in = COUNT_OUT_W'(alloc_ff);
               end else begin
                  key_in    = req_key;
                  rd_ptr_in = '0;
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (ram_rd_en) begin
               cmp_vld_in  = 1'b1;
               cmp_addr_in = rd_ptr_ff[IDX_W-1:0];
               rd_ptr_in   = rd_ptr_ff + CNT_W'(1);
            end
            if (scan_hit) begin
               // Lowest free slot with an equal key: claim it.
               in_use_in[cmp_addr_ff] = 1'b1;
               total_in       = total_ff + CNT_W'(1);
               rsp_valid_in   = 1'b1;
               rsp_slot_in    = SLOT_OUT_W'(cmp_addr_ff);
               rsp_created_in = 1'b0;
               rsp_full_in    = 1'b0;
               rsp_live_in    = COUNT_OUT_W'(total_in);
               retired_now    = alloc_in - total_in;
               rsp_retired_in = COUNT_OUT_W'(retired_now);
               state_in       = ST_IDLE;
            end else if (scan_miss) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (pool_is_full) begin
                  rsp_slot_in    = '0;
                  rsp_created_in = 1'b0;
                  rsp_full_in    = 1'b1;
               end else begin
                  // Open the next unused slot and store the key there.
                  in_use_in[alloc_ff[IDX_W-1:0]] = 1'b1;
                  alloc_in       = alloc_ff + CNT_W'(1);
                  total_in       = total_ff + CNT_W'(1);
                  rsp_slot_in    = SLOT_OUT_W'(alloc_ff);
                  rsp_created_in = 1'b1;
                  rsp_full_in    = 1'b0;
               end
               rsp_live_in    = COUNT_OUT_W'(total_in);
               retired_now    = alloc_in - total_in;
               rsp_retired_in = COUNT_OUT_W'(retired_now);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_vld_ff   <= 1'b0;
         in_use_ff    <= '0;
         alloc_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_vld_ff   <= cmp_vld_in;
         in_use_ff    <= in_use_in;
         alloc_ff     <= alloc_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff         <= key_in;
      rd_ptr_ff      <= rd_ptr_in;
      cmp_addr_ff    <= cmp_addr_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_created_ff <= rsp_created_in;
      rsp_full_ff    <= rsp_full_in;
      rsp_live_ff    <= rsp_live_in;
      rsp_retired_ff <= rsp_retired_in;
   end

   krp_key_ram #(
      .POOL_SLOTS (POOL_SLOTS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (key_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_ptr_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.slot_index    = rsp_slot_ff;
   assign rsp.created       = rsp_created_ff;
   assign rsp.pool_full     = rsp_full_ff;
   assign rsp.live_count    = rsp_live_ff;
   assign rsp.retired_count = rsp_retired_ff;

   // Slots in use can never outnumber the allocated slots, nor these the pool.
   `KRP_ASSERT_ALWAYS(a_total_le_alloc, clock, reset, total_ff <= alloc_ff)
   `KRP_ASSERT_ALWAYS(a_alloc_le_pool, clock, reset, alloc_ff <= CNT_W'(POOL_SLOTS))
   // Every accepted request either starts a scan or has its response ready next cycle.
   `KRP_ASSERT_NEXT(a_req_progress, clock, reset, req_fire,
      (state_ff == ST_SCAN) || rsp_valid_ff)
   // The read pointer never runs past the allocated slots during a scan.
   `KRP_ASSERT_ALWAYS(a_ptr_bound, clock, reset, (state_ff != ST_SCAN) || (rd_ptr_ff <= alloc_ff))
   // A scan only ends when the response register is free to take its result.
   `KRP_ASSERT_ALWAYS(a_rsp_free, clock, reset,
      !(scan_hit || scan_miss) || !rsp_valid_ff)

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for keyed_resource_pool_top: directed rows, then random frames of acquires ending in a retire.
// Depends on krp_pkg, krp_req_if, krp_rsp_if and the RTL of the keyed resource pool.
`timescale 1ns / 1ps
module testbench
   import krp_pkg::*;
   ();

   localparam int POOL_SLOTS  = POOL_SLOTS_DEF;
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 800;

   // A request, laid out so that the low KEY_W bits are exactly the stored key.
   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [DIM_W-1:0]   tex_height;
      logic [DIM_W-1:0]   tex_width;
      logic [FMT_W-1:0]   pixel_format;
      logic [USAGE_W-1:0] usage_bits;
      logic [TYPE_W-1:0]  tex_type;
      logic [MIP_W-1:0]   mip_levels;
      logic [LAYER_W-1:0] array_layers;
   } pool_req_type;

   typedef struct packed {
      logic [SLOT_OUT_W-1:0]  slot_index;
      logic                   created;
      logic                   pool_full;
      logic [COUNT_OUT_W-1:0] live_count;
      logic [COUNT_OUT_W-1:0] retired_count;
   } pool_rsp_type;

   // One row of the directed table. Where has_lit is set, the typed-in grant is the
   // expectation; otherwise the bench's own model of the pool supplies it.
   typedef struct {
      pool_req_type item;
      bit           has_lit;
      pool_rsp_type lit;
   } dir_row_type;

   logic clock;
   logic reset;

   krp_req_if req_bus ();
   krp_rsp_if rsp_bus ();

   keyed_resource_pool_top #(
      .POOL_SLOTS(POOL_SLOTS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req  (req_bus),
      .rsp  (rsp_bus)
   );

   // The bench's own copy of the pool: stored keys, in-use marks and the two counts.
   logic [KEY_W-1:0] slot_key [POOL_SLOTS];
   bit               slot_busy [POOL_SLOTS];
   int unsigned      slots_made;
   int unsigned      slots_live;

   pool_rsp_type pending_grants [$];
   dir_row_type  dir_rows [$];
   pool_rsp_type due;

   int mismatch_count = 0;
   int idle_pct       = 35;
   int quiet_cycles   = 0;
   int hold_left      = 0;
   bit hold_pending   = 1'b0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Applies one request to the bench's pool and returns the grant that the block must give.
   // A retire clears every in-use mark; an acquire takes the lowest free slot holding the same
   // key, else allocates the next unused slot, else reports the pool as full.
   function automatic pool_rsp_type pool_grant(input pool_req_type r);
      pool_rsp_type     g;
      logic [KEY_W-1:0] k;
      int               hit;
      g   = '0;
      k   = r[KEY_W-1:0];
      hit = -1;
      if (r.kind == KIND_RETIRE) begin
         foreach (slot_busy[s]) slot_busy[s] = 1'b0;
         slots_live = 0;
      end else begin
         for (int s = 0; s < slots_made; s++) begin
            if (hit < 0 && !slot_busy[s] && slot_key[s] == k) hit = s;
         end
         if (hit >= 0) begin
            slot_busy[hit] = 1'b1;
            slots_live++;
            g.slot_index = SLOT_OUT_W'(hit);
         end else if (slots_made >= POOL_SLOTS) begin
            g.pool_full = 1'b1;
         end else begin
            slot_key[slots_made]  = k;
            slot_busy[slots_made] = 1'b1;
            g.slot_index = SLOT_OUT_W'(slots_made);
            g.created    = 1'b1;
            slots_made++;
            slots_live++;
         end
      end
      g.live_count    = COUNT_OUT_W'(slots_live);
      g.retired_count = COUNT_OUT_W'(slots_made - slots_live);
      return g;
   endfunction

   function automatic pool_req_type acquire_of(input int fmt, input int w, input int h,
                                               input int usage, input int ttype,
                                               input int mips, input int layers);
      pool_req_type r;
      r.kind         = KIND_ACQUIRE;
      r.pixel_format = FMT_W'(fmt);
      r.tex_width    = DIM_W'(w);
      r.tex_height   = DIM_W'(h);
      r.usage_bits   = USAGE_W'(usage);
      r.tex_type     = TYPE_W'(ttype);
      r.mip_levels   = MIP_W'(mips);
      r.array_layers = LAYER_W'(layers);
      return r;
   endfunction

   function automatic pool_rsp_type grant_of(input int slot, input bit made, input bit full,
                                             input int live, input int retired);
      pool_rsp_type g;
      g.slot_index    = SLOT_OUT_W'(slot);
      g.created       = made;
      g.pool_full     = full;
      g.live_count    = COUNT_OUT_W'(live);
      g.retired_count = COUNT_OUT_W'(retired);
      return g;
   endfunction

   // Appends one row to the directed table.
   task automatic add_row(input pool_req_type item, input bit has_lit, input pool_rsp_type lit);
      dir_row_type row;
      row.item    = item;
      row.has_lit = has_lit;
      row.lit     = lit;
      dir_rows.insert(dir_rows.size(), row);
   endtask

   // Offers one request, holding valid high until the block takes it. Ready is sampled on
   // the falling edge, where it is stable up to the next rising edge, so the handshake does
   // not depend on the order of updates at the rising edge. Valid is only ever given one
   // assignment per edge, so back-to-back requests keep it high without a glitch.
   task automatic push_request(input pool_req_type r, input bit has_lit,
                               input pool_rsp_type lit);
      bit           taken;
      pool_rsp_type predicted;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.kind         <= r.kind;
      req_bus.pixel_format <= r.pixel_format;
      req_bus.tex_width    <= r.tex_width;
      req_bus.tex_height   <= r.tex_height;
      req_bus.usage_bits   <= r.usage_bits;
      req_bus.tex_type     <= r.tex_type;
      req_bus.mip_levels   <= r.mip_levels;
      req_bus.array_layers <= r.array_layers;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = (req_bus.ready === 1'b1);
         @(posedge clock);
      end
      // The model is always advanced, so that its state follows the block even on rows
      // whose expectation is typed in.
      predicted = pool_grant(r);
      pending_grants.insert(pending_grants.size(), has_lit ? lit : predicted);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   // Response side: ready is redrawn at every rising edge. A hold-off asked for by the
   // stimulus is counted here, in cycles, while the sender keeps offering requests, so
   // the response register fills and the block stops taking requests.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            hold_left    = 80;
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= idle_pct);
         end
      end
   end

   // Responses are compared on the falling edge, where valid, ready and the fields all hold
   // the values that the next rising edge will see.
   always @(negedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_grants.size() == 0) begin
            mismatch_count++;
            $display("%0t ns: response with no request outstanding, expected none, got slot %0d",
                     $time, rsp_bus.slot_index);
         end else begin
            due = pending_grants.pop_front();
            check_field("slot_index", 32'(due.slot_index), 32'(rsp_bus.slot_index));
            check_field("created", 32'(due.created), 32'(rsp_bus.created));
            check_field("pool_full", 32'(due.pool_full), 32'(rsp_bus.pool_full));
            check_field("live_count", 32'(due.live_count), 32'(rsp_bus.live_count));
            check_field("retired_count", 32'(due.retired_count), 32'(rsp_bus.retired_count));
         end
      end
   end

   // Watchdog: a long run of cycles in which neither side completes a handshake means the
   // block has hung.
   always @(negedge clock) begin
      if (reset || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles == STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      pool_req_type k_min, k_max, k_ones, k_zero, k, r;
      pool_rsp_type none;
      int           sent;
      int           frame_len;
      int           roll;

      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.kind         <= KIND_ACQUIRE;
      req_bus.pixel_format <= '0;
      req_bus.tex_width    <= '0;
      req_bus.tex_height   <= '0;
      req_bus.usage_bits   <= '0;
      req_bus.tex_type     <= '0;
      req_bus.mip_levels   <= '0;
      req_bus.array_layers <= '0;
      foreach (slot_busy[s]) slot_busy[s] = 1'b0;
      slots_made = 0;
      slots_live = 0;
      none       = '0;

      // Directed table. The smallest and largest legal keys, then keys with every bit set
      // and every bit clear, which lie outside the stated ranges and are stored as raw bits.
      k_min  = acquire_of(0, 1, 1, 0, 0, 1, 1);
      k_max  = acquire_of(255, 16384, 16384, 255, 7, 15, 2048);
      k_ones = acquire_of(-1, -1, -1, -1, -1, -1, -1);
      k_zero = acquire_of(0, 0, 0, 0, 0, 0, 0);
      r      = k_max;
      r.kind = KIND_RETIRE;

      // Fresh pool, then the same key again while its slot is busy: both allocate.
      add_row(k_min, 1'b1, grant_of(0, 1, 0, 1, 0));
      add_row(k_min, 1'b1, grant_of(1, 1, 0, 2, 0));
      add_row(k_max, 1'b1, grant_of(2, 1, 0, 3, 0));
      // Retire ignores its key fields and frees every slot.
      add_row(r, 1'b1, grant_of(0, 0, 0, 0, 3));
      // Reuse: the lowest free slot holding the key wins.
      add_row(k_min, 1'b1, grant_of(0, 0, 0, 1, 2));
      add_row(k_max, 1'b1, grant_of(2, 0, 0, 2, 1));
      add_row(k_min, 1'b1, grant_of(1, 0, 0, 3, 0));
      add_row(k_ones, 1'b1, grant_of(3, 1, 0, 4, 0));
      add_row(k_zero, 1'b1, grant_of(4, 1, 0, 5, 0));
      // Keys that differ from the smallest key in one field only, so that every field
      // takes part in the compare; these fill the remaining slots.
      for (int i = 0; i < 11; i++) begin
         k = k_min;
         case (i % 7)
            0: k.pixel_format += FMT_W'(1 + i / 7);
            1: k.tex_width    += DIM_W'(1 + i / 7);
            2: k.tex_height   += DIM_W'(1 + i / 7);
            3: k.usage_bits   += USAGE_W'(1 + i / 7);
            4: k.tex_type     += TYPE_W'(1);
            5: k.mip_levels   += MIP_W'(1);
            default: k.array_layers += LAYER_W'(1);
         endcase
         add_row(k, 1'b0, none);
      end
      // Pool full: a new key, then a known key whose slots are all busy.
      k = k_min;
      k.tex_type = TYPE_W'(5);
      add_row(k, 1'b1, grant_of(0, 0, 1, 16, 0));
      add_row(k_min, 1'b1, grant_of(0, 0, 1, 16, 0));
      add_row(r, 1'b1, grant_of(0, 0, 0, 0, 16));
      add_row(k_ones, 1'b1, grant_of(3, 0, 0, 1, 15));
      k = k_min;
      k.usage_bits = USAGE_W'(9);
      add_row(k, 1'b1, grant_of(0, 0, 1, 1, 15));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) push_request(dir_rows[i].item, dir_rows[i].has_lit, dir_rows[i].lit);

      // Random frames: a run of acquires, then a retire. Most acquires name a key that is
      // already stored, so slots are reused and duplicates pile up until the pool is full;
      // the rest are near misses with one key bit flipped, fully random keys, or a stray
      // retire in the middle of a frame.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         frame_len = $urandom_range(1, 24);
         for (int j = 0; j <= frame_len; j++) begin
            idle_pct = (sent >= 300 && sent < 450) ? 0 : 35;
            if (sent == 120 || sent == 350) hold_pending = 1'b1;
            roll = $urandom_range(0, 99);
            if (j == frame_len || roll >= 97) begin
               r = {KIND_RETIRE, KEY_W'({$urandom(), $urandom(), $urandom()})};
            end else if (roll < 75 && slots_made > 0) begin
               r = {KIND_ACQUIRE, slot_key[$urandom_range(0, slots_made - 1)]};
            end else if (roll < 85 && slots_made > 0) begin
               r = {KIND_ACQUIRE, slot_key[$urandom_range(0, slots_made - 1)] ^
                                  (KEY_W'(1) << $urandom_range(0, KEY_W - 1))};
            end else begin
               r = {KIND_ACQUIRE, KEY_W'({$urandom(), $urandom(), $urandom()})};
            end
            push_request(r, 1'b0, none);
            sent++;
         end
      end
      idle_pct = 35;
      req_bus.valid <= 1'b0;

      // Drain, then give the block time to show any response that nobody asked for.
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (POOL_SLOTS + 4) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/krp_pkg.sv
hdl/krp_req_if.sv
hdl/krp_rsp_if.sv
hdl/krp_key_ram.sv
hdl/keyed_resource_pool_top.sv
bench/testbench.sv
